### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/icm_pkg.sv
package icm_pkg;

  localparam int MEM_WORDS_DEF   = 1024;
  localparam int MAX_OUTPUTS_DEF = 63;

  localparam logic signed [31:0] INPUT_VALUE_RESET = 32'sd1;

  // Reciprocal constants for exact unsigned 32-bit division by 100 and by 10.
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int          DIV100_SHIFT = 37;
  localparam logic [31:0] DIV10_MAGIC  = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT  = 35;

  localparam logic [6:0] OP_ADD  = 7'd1;
  localparam logic [6:0] OP_MUL  = 7'd2;
  localparam logic [6:0] OP_IN   = 7'd3;
  localparam logic [6:0] OP_OUT  = 7'd4;
  localparam logic [6:0] OP_HALT = 7'd99;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OUT   = 3'd0,
    ST_HALT  = 3'd1,
    ST_END   = 3'd2,
    ST_OPC   = 3'd3,
    ST_ADDR  = 3'd4,
    ST_LIMIT = 3'd5,
    ST_FULL  = 3'd6
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_MUL = 1'b1
  } alu_kind_t;

  typedef struct packed {
    logic              go;
    alu_kind_t         kind;
    logic [31:0]       a;
    logic [31:0]       b;
  } alu_req_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [31:0] word;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic signed [31:0] value;
    logic              last;
  } rsp_t;

endpackage

### hw/rtl/intcode_machine_core_top.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  icm_pkg::req_t  (cmd, word)
// rsp       out        rsp_valid/rsp_stall  icm_pkg::rsp_t  (status, value, last)
// cfg       in         cfg_we               cfg_data (input_value)
//
// Load and clear are handled in the idle state; a load writes one word per cycle while no run holds req_stall.
// A run fetches, decodes and dispatches each instruction, then reads
// operands and writes back an add or multiply, sharing the single
// program memory port and the shared add/multiply unit; a closing
// status item ends the run.
// Reset is synchronous; it empties the program and sets input_value to 1.
// Program memory has no clearing pass. One result register parts the
// output side: a load is taken while a result waits, a stalled rsp holds
// the sequencer only where it must post a new result.
`include "assert_macros.svh"

module intcode_machine_core_top #(
  parameter int MEM_WORDS   = icm_pkg::MEM_WORDS_DEF,
  parameter int MAX_OUTPUTS = icm_pkg::MAX_OUTPUTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  icm_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output icm_pkg::rsp_t      rsp,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data
);

  localparam int LW = $clog2(MEM_WORDS + 1);   // length and counter width
  localparam int AW = $clog2(MEM_WORDS);       // memory address width
  localparam int EW = $clog2(MAX_OUTPUTS + 1); // output count width

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH, S_DEC0, S_DEC1, S_DEC2, S_DEC3, S_DEC4, S_EXEC,
    S_OPND_RD, S_OPND_PTR, S_OPND_VAL, S_DST_RD, S_DST_CHK,
    S_ALU_GO, S_ALU_WB, S_OUT_EMIT, S_FINISH
  } state_t;

  state_t             state;
  logic [LW-1:0]      len;
  logic [LW-1:0]      pc;
  logic [EW-1:0]      emitted;
  logic signed [31:0] input_value;

  // Decode and operand registers.
  logic [31:0]        w;
  logic [31:0]        qreg;
  logic [6:0]         op;
  logic               m1, m2, m3;
  logic               opn;
  logic [31:0]        a_val, b_val;
  logic [LW-1:0]      dst;
  icm_pkg::status_t   fin_status;

  // Memory and shared unit.
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [31:0]        ram_wdata;
  logic [31:0]        rdata;
  icm_pkg::alu_req_t  alu_req;
  logic [63:0]        prod;

  logic               out_free;
  logic               rsp_post;
  logic               mem_full;
  logic               req_xfer;
  logic [31:0]        len32;
  logic [LW+1:0]      len_x, pc1, pc3, slot_opnd, dst_slot;
  logic [31:0]        q100, q10, rem_op, rem_dig;
  logic               imm_cur;

  icm_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(rdata)
  );

  icm_alu u_alu (
    .clk (clk),
    .req (alu_req),
    .prod(prod)
  );

  assign req_stall = (state != S_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  // A new result goes into the output register this cycle.
  assign rsp_post  = out_free && ((state == S_FINISH) ||
                     ((state == S_OUT_EMIT) && (emitted < EW'(MAX_OUTPUTS))));
  assign mem_full  = (len == LW'(MEM_WORDS));
  assign len32     = 32'(len);
  assign len_x     = {2'b00, len};
  assign pc1       = {2'b00, pc} + (LW+2)'(1);
  assign pc3       = {2'b00, pc} + (LW+2)'(3);
  assign slot_opnd = pc1 + (LW+2)'(opn);
  assign dst_slot  = (op == icm_pkg::OP_IN) ? pc1 : pc3;
  assign imm_cur   = opn ? m2 : m1;

  // Quotients from the previous multiply; remainders by shift and add.
  assign q100    = 32'(prod[63:icm_pkg::DIV100_SHIFT]);
  assign q10     = 32'(prod[63:icm_pkg::DIV10_SHIFT]);
  assign rem_op  = w - ((q100 << 6) + (q100 << 5) + (q100 << 2));
  assign rem_dig = qreg - ((q10 << 3) + (q10 << 1));

  // Steer the memory port and the shared unit from the current state.
  always_comb begin
    ram_we       = 1'b0;
    ram_addr     = pc[AW-1:0];
    ram_wdata    = req.word;
    alu_req.go   = 1'b0;
    alu_req.kind = icm_pkg::ALU_MUL;
    alu_req.a    = rdata;
    alu_req.b    = icm_pkg::DIV10_MAGIC;
    unique case (state)
      S_IDLE: begin
        ram_addr = len[AW-1:0];
        ram_we   = req_xfer && (req.cmd == icm_pkg::CMD_LOAD) && !mem_full;
      end
      S_DEC0: begin
        alu_req.go = 1'b1;
        alu_req.b  = icm_pkg::DIV100_MAGIC;
      end
      S_DEC1: begin
        alu_req.go = 1'b1;
        alu_req.a  = q100;
      end
      S_DEC2, S_DEC3: begin
        alu_req.go = 1'b1;
        alu_req.a  = q10;
      end
      S_OPND_RD:  ram_addr = slot_opnd[AW-1:0];
      S_OPND_PTR: ram_addr = rdata[AW-1:0];
      S_DST_RD:   ram_addr = dst_slot[AW-1:0];
      S_DST_CHK: begin
        ram_addr  = rdata[AW-1:0];
        ram_wdata = input_value;
        ram_we    = (op == icm_pkg::OP_IN) && (rdata < len32);
      end
      S_ALU_GO: begin
        alu_req.go   = 1'b1;
        alu_req.kind = (op == icm_pkg::OP_ADD) ? icm_pkg::ALU_ADD : icm_pkg::ALU_MUL;
        alu_req.a    = a_val;
        alu_req.b    = b_val;
      end
      S_ALU_WB: begin
        ram_addr  = dst[AW-1:0];
        ram_wdata = prod[31:0];
        ram_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_value <= icm_pkg::INPUT_VALUE_RESET;
    end else if (cfg_we) begin
      input_value <= cfg_data;
    end
  end

  // Sequencer: state, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      pc        <= '0;
      emitted   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise valid with each new result; drop it once the transfer completes.
      if (rsp_post) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_xfer) begin
            priority if (req.cmd == icm_pkg::CMD_LOAD) begin
              if (mem_full) begin
                fin_status <= icm_pkg::ST_FULL;
                state      <= S_FINISH;
              end else begin
                len <= len + LW'(1);
              end
            end else if (req.cmd == icm_pkg::CMD_RUN) begin
              pc      <= '0;
              emitted <= '0;
              state   <= S_FETCH;
            end else if (req.cmd == icm_pkg::CMD_CLEAR) begin
              len     <= '0;
              pc      <= '0;
              emitted <= '0;
            end else begin
              // Drop an unused command.
            end
          end
        end
        S_FETCH: begin
          if (pc >= len) begin
            fin_status <= icm_pkg::ST_END;
            state      <= S_FINISH;
          end else begin
            state <= S_DEC0;
          end
        end
        S_DEC0: begin
          w <= rdata;
          if (rdata[31]) begin
            fin_status <= icm_pkg::ST_OPC;
            state      <= S_FINISH;
          end else begin
            state <= S_DEC1;
          end
        end
        S_DEC1: begin
          op    <= rem_op[6:0];
          qreg  <= q100;
          state <= S_DEC2;
        end
        S_DEC2: begin
          m1    <= (rem_dig == 32'd1);
          qreg  <= q10;
          state <= S_DEC3;
        end
        S_DEC3: begin
          m2    <= (rem_dig == 32'd1);
          qreg  <= q10;
          state <= S_DEC4;
        end
        S_DEC4: begin
          m3    <= (rem_dig == 32'd1);
          state <= S_EXEC;
        end
        S_EXEC: begin
          opn <= 1'b0;
          unique case (op)
            icm_pkg::OP_HALT: begin
              fin_status <= icm_pkg::ST_HALT;
              state      <= S_FINISH;
            end
            icm_pkg::OP_ADD, icm_pkg::OP_MUL: begin
              if (pc3 >= len_x) begin
                fin_status <= icm_pkg::ST_END;
                state      <= S_FINISH;
              end else begin
                state <= S_OPND_RD;
              end
            end
            icm_pkg::OP_IN: begin
              if (pc1 >= len_x) begin
                fin_status <= icm_pkg::ST_END;
                state      <= S_FINISH;
              end else begin
                state <= S_DST_RD;
              end
            end
            icm_pkg::OP_OUT: state <= S_OPND_RD;
            default: begin
              fin_status <= icm_pkg::ST_OPC;
              state      <= S_FINISH;
            end
          endcase
        end
        S_OPND_RD: begin
          if (slot_opnd >= len_x) begin
            fin_status <= icm_pkg::ST_END;
            state      <= S_FINISH;
          end else begin
            state <= S_OPND_PTR;
          end
        end
        S_OPND_PTR, S_OPND_VAL: begin
          if (state == S_OPND_PTR && !imm_cur) begin
            // Position mode: follow the pointer if it lies inside the program.
            if (rdata >= len32) begin
              fin_status <= icm_pkg::ST_ADDR;
              state      <= S_FINISH;
            end else begin
              state <= S_OPND_VAL;
            end
          end else begin
            if (opn) begin
              b_val <= rdata;
            end else begin
              a_val <= rdata;
            end
            priority if (op == icm_pkg::OP_OUT) begin
              state <= S_OUT_EMIT;
            end else if (!opn) begin
              opn   <= 1'b1;
              state <= S_OPND_RD;
            end else begin
              state <= S_DST_RD;
            end
          end
        end
        S_DST_RD: begin
          if (op != icm_pkg::OP_IN && m3) begin
            dst   <= pc3[LW-1:0];
            state <= S_ALU_GO;
          end else begin
            state <= S_DST_CHK;
          end
        end
        S_DST_CHK: begin
          priority if (rdata >= len32) begin
            fin_status <= icm_pkg::ST_ADDR;
            state      <= S_FINISH;
          end else if (op == icm_pkg::OP_IN) begin
            pc    <= pc + LW'(2);
            state <= S_FETCH;
          end else begin
            dst   <= rdata[LW-1:0];
            state <= S_ALU_GO;
          end
        end
        S_ALU_GO: state <= S_ALU_WB;
        S_ALU_WB: begin
          pc    <= pc + LW'(4);
          state <= S_FETCH;
        end
        S_OUT_EMIT: begin
          if (emitted >= EW'(MAX_OUTPUTS)) begin
            fin_status <= icm_pkg::ST_LIMIT;
            state      <= S_FINISH;
          end else if (out_free) begin
            rsp.status   <= icm_pkg::ST_OUT;
            rsp.value    <= a_val;
            rsp.last     <= 1'b0;
            emitted      <= emitted + EW'(1);
            pc           <= pc + LW'(2);
            state        <= S_FETCH;
          end
        end
        S_FINISH: begin
          // Hold until the result register frees, then post the status item.
          if (out_free) begin
            rsp.status <= fin_status;
            rsp.value  <= '0;
            rsp.last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_len_bound, clk, rst, len <= LW'(MEM_WORDS), "program length past memory size")
  `ASSERT_ALWAYS(a_emit_bound, clk, rst, emitted <= EW'(MAX_OUTPUTS), "output count past limit")
  `ASSERT_IMPLY(a_fetch_pc, clk, rst, state == S_FETCH, pc <= len, "counter skipped past the end")
  `ASSERT_IMPLY(a_run_write, clk, rst, ram_we && state != S_IDLE, LW'(ram_addr) < len, "bad run write")

endmodule

### hw/rtl/icm_ram.sv
module icm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/icm_alu.sv
module icm_alu (
  input  logic             clk,
  input  icm_pkg::alu_req_t req,
  output logic [63:0]      prod
);

  // Hold the last result until the next request.
  always_ff @(posedge clk) begin
    if (req.go) begin
      unique case (req.kind)
        icm_pkg::ALU_ADD: prod <= {32'd0, req.a + req.b};
        icm_pkg::ALU_MUL: prod <= {32'd0, req.a} * {32'd0, req.b};
        default:          prod <= {32'd0, req.a + req.b};
      endcase
    end
  end

endmodule
